>>> design/rfhp_pkg.sv
`timescale 1ns / 1ps
// rfhp_pkg: shared types and frame layout constants for the radio frame
// header parser. No dependencies.
package rfhp_pkg;

   localparam int POS_W = 4;
   localparam int LEN_W = 5;

   localparam logic [7:0] TYPE_MASK   = 8'h3F;
   localparam int         EXT_BIT     = 7;
   localparam int         FWD_BIT     = 6;
   localparam int         ACK_SHIFT   = 6;
   localparam int         UNICAST_BIT = 5;
   localparam int         SIG_BIT     = 4;

   localparam logic [POS_W-1:0] BASE_LEN = 4'd4;
   localparam logic [POS_W-1:0] ADDR_LEN = 4'd3;
   localparam logic [POS_W-1:0] SIG_LEN  = 4'd4;
   localparam logic [POS_W-1:0] LAST_POS = 4'd11;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_TRUNC   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } beat_type;

   typedef struct packed {
      kind_type    kind;
      logic        forward;
      logic [5:0]  frame_type;
      logic [1:0]  ack_type;
      logic [7:0]  src_manufacturer;
      logic [15:0] src_id;
      logic [7:0]  dest_manufacturer;
      logic [15:0] dest_id;
      logic [31:0] sig_word;
      logic [7:0]  payload_byte;
      logic        end_of_frame;
      logic [7:0]  payload_count;
   } result_type;

endpackage

>>> design/rfhp_in_stage.sv
`timescale 1ns / 1ps
// rfhp_in_stage: input register for received beats.
// Depends on rfhp_pkg.
module rfhp_in_stage import rfhp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  beat_type req_beat,
   input  logic     slot_free,
   output logic     fire,
   output beat_type beat
);

   logic     vld_ff, vld_in;
   beat_type beat_ff;

   assign fire      = vld_ff && slot_free;
   assign req_ready = !vld_ff || fire;
   assign beat      = beat_ff;

   always_comb begin
      vld_in = vld_ff;
      if (req_valid && req_ready) begin
         vld_in = 1'b1;
      end else if (fire) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beat_ff <= req_beat;
      end
   end

endmodule

>>> design/rfhp_core.sv
`timescale 1ns / 1ps
// rfhp_core: header state, field capture and result formation for one beat.
// Depends on rfhp_pkg.
module rfhp_core import rfhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  beat_type   beat,
   output logic       res_valid,
   output result_type res
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             done_ff, done_in;
   logic [7:0]       hdr_ff, hdr_in;
   logic [7:0]       ext_ff, ext_in;
   logic [23:0]      src_ff, src_in;
   logic [23:0]      dest_ff, dest_in;
   logic [31:0]      sig_ff, sig_in;
   logic [7:0]       cnt_ff, cnt_in;

   logic [7:0]       hdr_nx, ext_nx;
   logic [23:0]      src_nx, dest_nx;
   logic [31:0]      sig_nx;
   logic [7:0]       cnt_nx;
   logic             has_ext, has_uni, has_sig;
   logic [LEN_W-1:0] hdr_len;
   logic [POS_W-1:0] sig_start;
   logic             complete;

   always_comb begin
      hdr_nx  = (pos_ff == '0) ? beat.rx_byte : hdr_ff;
      ext_nx  = (pos_ff == BASE_LEN) ? beat.rx_byte : ext_ff;
      has_ext = hdr_nx[EXT_BIT];
      has_uni = has_ext && ext_nx[UNICAST_BIT];
      has_sig = has_ext && ext_nx[SIG_BIT];

      hdr_len = {1'b0, BASE_LEN};
      if (has_ext) begin
         hdr_len = hdr_len + LEN_W'(1);
         if (has_uni) hdr_len = hdr_len + {1'b0, ADDR_LEN};
         if (has_sig) hdr_len = hdr_len + {1'b0, SIG_LEN};
      end
      sig_start = BASE_LEN + POS_W'(1) + (has_uni ? ADDR_LEN : '0);

      src_nx = src_ff;
      for (int i = 0; i < 3; i++) begin
         if (pos_ff == POS_W'(1 + i)) src_nx[8*i +: 8] = beat.rx_byte;
      end
      dest_nx = dest_ff;
      for (int i = 0; i < 3; i++) begin
         if (has_uni && pos_ff == BASE_LEN + POS_W'(1 + i)) begin
            dest_nx[8*i +: 8] = beat.rx_byte;
         end
      end
      sig_nx = sig_ff;
      for (int i = 0; i < 4; i++) begin
         if (has_sig && pos_ff == sig_start + POS_W'(i)) sig_nx[8*i +: 8] = beat.rx_byte;
      end

      complete = ({1'b0, pos_ff} + LEN_W'(1)) >= hdr_len;
      cnt_nx   = (cnt_ff == 8'hFF) ? cnt_ff : cnt_ff + 8'd1;
   end

   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      if (done_ff) begin
         res_valid         = 1'b1;
         res.kind          = KIND_PAYLOAD;
         res.payload_byte  = beat.rx_byte;
         res.end_of_frame  = beat.frame_end;
         res.payload_count = cnt_nx;
      end else if (complete) begin
         res_valid             = 1'b1;
         res.kind              = KIND_HEADER;
         res.forward           = hdr_nx[FWD_BIT];
         res.frame_type        = 6'(hdr_nx & TYPE_MASK);
         res.ack_type          = has_ext ? ext_nx[ACK_SHIFT +: 2] : 2'd0;
         res.src_manufacturer  = src_nx[7:0];
         res.src_id            = src_nx[23:8];
         res.dest_manufacturer = dest_nx[7:0];
         res.dest_id           = dest_nx[23:8];
         res.sig_word          = sig_nx;
         res.end_of_frame      = beat.frame_end;
      end else if (beat.frame_end) begin
         res_valid        = 1'b1;
         res.kind         = KIND_TRUNC;
         res.end_of_frame = 1'b1;
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      hdr_in  = hdr_ff;
      ext_in  = ext_ff;
      src_in  = src_ff;
      dest_in = dest_ff;
      sig_in  = sig_ff;
      cnt_in  = cnt_ff;
      if (fire) begin
         if (beat.frame_end) begin
            pos_in  = '0;
            done_in = 1'b0;
            hdr_in  = '0;
            ext_in  = '0;
            src_in  = '0;
            dest_in = '0;
            sig_in  = '0;
            cnt_in  = '0;
         end else if (done_ff) begin
            cnt_in = cnt_nx;
         end else begin
            hdr_in  = hdr_nx;
            ext_in  = ext_nx;
            src_in  = src_nx;
            dest_in = dest_nx;
            sig_in  = sig_nx;
            if (complete) begin
               done_in = 1'b1;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b0;
         hdr_ff  <= '0;
         ext_ff  <= '0;
         src_ff  <= '0;
         dest_ff <= '0;
         sig_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
         hdr_ff  <= hdr_in;
         ext_ff  <= ext_in;
         src_ff  <= src_in;
         dest_ff <= dest_in;
         sig_ff  <= sig_in;
         cnt_ff  <= cnt_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("header position beyond longest header");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      fire && beat.frame_end |=> pos_ff == '0 && !done_ff && cnt_ff == '0)
      else $error("state not cleared after frame end");

   a_payload_after_header: assert property (@(posedge clock) disable iff (reset)
      fire && done_ff |-> res_valid && res.kind == KIND_PAYLOAD)
      else $error("byte after header not passed as payload");

   a_header_sets_done: assert property (@(posedge clock) disable iff (reset)
      fire && !done_ff && res_valid && res.kind == KIND_HEADER && !beat.frame_end
      |=> done_ff)
      else $error("header record without header completion");

endmodule

>>> design/rfhp_out_stage.sv
`timescale 1ns / 1ps
// rfhp_out_stage: result register toward the response channel.
// Depends on rfhp_pkg.
module rfhp_out_stage import rfhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   output logic       slot_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic       vld_ff, vld_in;
   result_type res_ff;

   assign slot_free = !vld_ff || rsp_ready;
   assign rsp_valid = vld_ff;
   assign rsp       = res_ff;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

endmodule

>>> design/radio_frame_header_parser.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   rx_byte, frame_end
// rsp_      out        rsp_valid/rsp_ready   header record, payload byte or truncation
//
// One beat per cycle sustained while rsp_ready does not stall; a result reaches rsp through
// the input register and then the result register, and rsp_valid rises once it is loaded.
// Synchronous active-high reset clears all frame state; the first beat starts a frame.
// A stalled rsp_ready holds the result register; the input register still takes one
// more beat, then req_ready drops.
// Depends on rfhp_pkg, rfhp_in_stage, rfhp_core, rfhp_out_stage.
module radio_frame_header_parser import rfhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic        rsp_forward,
   output logic [5:0]  rsp_frame_type,
   output logic [1:0]  rsp_ack_type,
   output logic [7:0]  rsp_src_manufacturer,
   output logic [15:0] rsp_src_id,
   output logic [7:0]  rsp_dest_manufacturer,
   output logic [15:0] rsp_dest_id,
   output logic [31:0] rsp_sig_word,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_end_of_frame,
   output logic [7:0]  rsp_payload_count
);

   beat_type   req_beat, beat;
   logic       slot_free, fire, res_valid;
   result_type res, rsp;

   assign req_beat.rx_byte   = req_rx_byte;
   assign req_beat.frame_end = req_frame_end;

   rfhp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .slot_free (slot_free),
      .fire      (fire),
      .beat      (beat)
   );

   rfhp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .beat      (beat),
      .res_valid (res_valid),
      .res       (res)
   );

   rfhp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind              = rsp.kind;
   assign rsp_forward           = rsp.forward;
   assign rsp_frame_type        = rsp.frame_type;
   assign rsp_ack_type          = rsp.ack_type;
   assign rsp_src_manufacturer  = rsp.src_manufacturer;
   assign rsp_src_id            = rsp.src_id;
   assign rsp_dest_manufacturer = rsp.dest_manufacturer;
   assign rsp_dest_id           = rsp.dest_id;
   assign rsp_sig_word          = rsp.sig_word;
   assign rsp_payload_byte      = rsp.payload_byte;
   assign rsp_end_of_frame      = rsp.end_of_frame;
   assign rsp_payload_count     = rsp.payload_count;

endmodule

>>> bench/rfhp_frame_checker.sv
`timescale 1ns / 1ps
// rfhp_frame_checker: watches both channels of the radio frame header parser,
// predicts each result from the accepted input beats and compares. Uses rfhp_pkg.
module rfhp_frame_checker import rfhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic        rsp_forward,
   input  logic [5:0]  rsp_frame_type,
   input  logic [1:0]  rsp_ack_type,
   input  logic [7:0]  rsp_src_manufacturer,
   input  logic [15:0] rsp_src_id,
   input  logic [7:0]  rsp_dest_manufacturer,
   input  logic [15:0] rsp_dest_id,
   input  logic [31:0] rsp_sig_word,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_end_of_frame,
   input  logic [7:0]  rsp_payload_count,
   output int          mismatch_count,
   output int          pending_count
);

   logic [3:0]  hdr_pos;
   logic        hdr_complete;
   logic [7:0]  hdr_byte0;
   logic [7:0]  hdr_ext;
   logic [23:0] src_addr;
   logic [23:0] dest_addr;
   logic [31:0] sig_acc;
   logic [7:0]  payload_seen;

   result_type  parsed_q[$];

   task automatic clear_frame();
      hdr_pos      = '0;
      hdr_complete = 1'b0;
      hdr_byte0    = '0;
      hdr_ext      = '0;
      src_addr     = '0;
      dest_addr    = '0;
      sig_acc      = '0;
      payload_seen = '0;
   endtask

   task automatic parse_rx_byte(input logic [7:0] b, input logic last);
      result_type res;
      logic       ext, uni, sig;
      int         p, hlen, sig_start;
      res = '0;
      if (hdr_complete) begin
         if (payload_seen != 8'd255) payload_seen = payload_seen + 8'd1;
         res.kind          = KIND_PAYLOAD;
         res.payload_byte  = b;
         res.end_of_frame  = last;
         res.payload_count = payload_seen;
         parsed_q.push_back(res);
      end else begin
         p         = int'(hdr_pos);
         ext       = hdr_byte0[EXT_BIT];
         uni       = ext & hdr_ext[UNICAST_BIT];
         sig       = ext & hdr_ext[SIG_BIT];
         sig_start = int'(BASE_LEN) + 1 + (uni ? int'(ADDR_LEN) : 0);
         if (p == 0) begin
            hdr_byte0 = b;
         end else if (p < int'(BASE_LEN)) begin
            src_addr = src_addr | (24'(b) << (8 * (p - 1)));
         end else if (p == int'(BASE_LEN)) begin
            hdr_ext = b;
         end else if (uni && p < int'(BASE_LEN) + 1 + int'(ADDR_LEN)) begin
            dest_addr = dest_addr | (24'(b) << (8 * (p - int'(BASE_LEN) - 1)));
         end else if (sig && p >= sig_start && p < sig_start + int'(SIG_LEN)) begin
            sig_acc = sig_acc | (32'(b) << (8 * (p - sig_start)));
         end
         ext  = hdr_byte0[EXT_BIT];
         uni  = ext & hdr_ext[UNICAST_BIT];
         sig  = ext & hdr_ext[SIG_BIT];
         hlen = int'(BASE_LEN);
         if (ext) hlen = hlen + 1 + (uni ? int'(ADDR_LEN) : 0) + (sig ? int'(SIG_LEN) : 0);
         if (p + 1 >= hlen) begin
            hdr_complete          = 1'b1;
            res.kind              = KIND_HEADER;
            res.forward           = hdr_byte0[FWD_BIT];
            res.frame_type        = 6'(hdr_byte0 & TYPE_MASK);
            res.ack_type          = ext ? hdr_ext[ACK_SHIFT +: 2] : 2'd0;
            res.src_manufacturer  = src_addr[7:0];
            res.src_id            = src_addr[23:8];
            res.dest_manufacturer = dest_addr[7:0];
            res.dest_id           = dest_addr[23:8];
            res.sig_word          = sig_acc;
            res.end_of_frame      = last;
            parsed_q.push_back(res);
         end else begin
            hdr_pos = 4'(p + 1);
            if (last) begin
               res.kind         = KIND_TRUNC;
               res.end_of_frame = 1'b1;
               parsed_q.push_back(res);
            end
         end
      end
      if (last) clear_frame();
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   initial begin
      clear_frame();
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) parse_rx_byte(req_rx_byte, req_frame_end);
         if (rsp_valid && rsp_ready) begin
            if (parsed_q.size() == 0) begin
               $error("result beat with nothing expected: kind %0d", rsp_kind);
               mismatch_count++;
            end else begin
               want = parsed_q.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("forward", 32'(want.forward), 32'(rsp_forward));
               check_field("frame_type", 32'(want.frame_type), 32'(rsp_frame_type));
               check_field("ack_type", 32'(want.ack_type), 32'(rsp_ack_type));
               check_field("src_manufacturer", 32'(want.src_manufacturer),
                           32'(rsp_src_manufacturer));
               check_field("src_id", 32'(want.src_id), 32'(rsp_src_id));
               check_field("dest_manufacturer", 32'(want.dest_manufacturer),
                           32'(rsp_dest_manufacturer));
               check_field("dest_id", 32'(want.dest_id), 32'(rsp_dest_id));
               check_field("sig_word", want.sig_word, rsp_sig_word);
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
               check_field("end_of_frame", 32'(want.end_of_frame), 32'(rsp_end_of_frame));
               check_field("payload_count", 32'(want.payload_count),
                           32'(rsp_payload_count));
            end
         end
         pending_count = parsed_q.size();
      end
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives frames into radio_frame_header_parser and gives the verdict.
// Depends on rfhp_pkg, the parser RTL and rfhp_frame_checker.
module tb_top import rfhp_pkg::*;;

   localparam int RANDOM_BEATS = 800;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLDOFF      = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        req_frame_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic        rsp_forward;
   logic [5:0]  rsp_frame_type;
   logic [1:0]  rsp_ack_type;
   logic [7:0]  rsp_src_manufacturer;
   logic [15:0] rsp_src_id;
   logic [7:0]  rsp_dest_manufacturer;
   logic [15:0] rsp_dest_id;
   logic [31:0] rsp_sig_word;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_end_of_frame;
   logic [7:0]  rsp_payload_count;

   int          mismatch_count;
   int          pending_count;
   int          beats_sent;
   int          phase;
   int          quiet_cycles;
   bit          holdoff_done;
   bit          long_frame_done;
   logic [7:0]  frame_q[$];

   radio_frame_header_parser dut (.*);

   rfhp_frame_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(input logic [7:0] b, input logic last);
      int idle_pct;
      idle_pct = (phase == 0) ? 37 : (phase == 1) ? 65 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= b;
      req_frame_end <= last;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      phase = (beats_sent < 300) ? 0 : (beats_sent < 600) ? 1 : 2;
      @(negedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) send_beat(frame_q[i], i == frame_q.size() - 1);
   endtask

   function automatic int header_len(input logic [7:0] b0, input logic [7:0] ext);
      int n;
      n = int'(BASE_LEN);
      if (b0[EXT_BIT])
         n = n + 1 + (ext[UNICAST_BIT] ? int'(ADDR_LEN) : 0) + (ext[SIG_BIT] ? int'(SIG_LEN) : 0);
      return n;
   endfunction

   task automatic build_header(output int hlen);
      logic [7:0] b0, ext;
      b0  = 8'($urandom_range(0, 255));
      ext = 8'($urandom_range(0, 255));
      hlen = header_len(b0, ext);
      frame_q.delete();
      frame_q.push_back(b0);
      for (int i = 1; i < hlen; i++)
         frame_q.push_back((i == int'(BASE_LEN)) ? ext : 8'($urandom_range(0, 255)));
   endtask

   initial begin
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (phase == 1 && !holdoff_done) begin
            holdoff_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= ((phase == 0) ? 65 : (phase == 1) ? 37 : 0));
      end
   end

   initial begin
      int hlen, plen, sel, n;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = '0;
      req_frame_end = 1'b0;
      beats_sent    = 0;
      phase         = 0;
      quiet_cycles  = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // minimal header closed by its own last byte
      frame_q = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      // all-ones header with unicast, signature and ack 3, then two payload beats
      frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_frame();
      // truncated on the first byte, then truncated in the destination
      frame_q = '{8'h80};
      send_frame();
      frame_q = '{8'h80, 8'h01, 8'h02, 8'h03, 8'h20, 8'h05};
      send_frame();

      n = beats_sent;
      while (beats_sent < n + RANDOM_BEATS) begin
         sel = $urandom_range(0, 99);
         if (beats_sent >= 450 && !long_frame_done) begin
            // drives the payload counter into saturation
            long_frame_done = 1'b1;
            build_header(hlen);
            for (int i = 0; i < 300; i++) frame_q.push_back(8'($urandom_range(0, 255)));
            send_frame();
         end else if (sel < 70) begin
            build_header(hlen);
            plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < plen; i++) frame_q.push_back(8'($urandom_range(0, 255)));
            send_frame();
         end else if (sel < 85) begin
            build_header(hlen);
            plen = $urandom_range(1, hlen - 1);
            while (frame_q.size() > plen) void'(frame_q.pop_back());
            send_frame();
         end else begin
            plen = $urandom_range(1, 12);
            for (int i = 0; i < plen; i++)
               send_beat(8'($urandom_range(0, 255)),
                         (i == plen - 1) || ($urandom_range(0, 7) == 0));
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
design/rfhp_pkg.sv
design/rfhp_in_stage.sv
design/rfhp_core.sv
design/rfhp_out_stage.sv
design/radio_frame_header_parser.sv
bench/rfhp_frame_checker.sv
bench/tb_top.sv
